// File: hdl/tcl_pkg.sv
// tcl_pkg: token codes, character constants, token record type and the
// keyword prefix function shared by the lexer core and its channel interfaces.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcl_pkg;

	localparam int unsigned POS_W         = 32;
	localparam int unsigned LEN_W         = 16;
	localparam int unsigned MAX_TOKEN_LEN = 65535;

	typedef logic [2:0]       tok_type_t;
	typedef logic [7:0]       char_t;
	typedef logic [LEN_W-1:0] tok_len_t;
	typedef logic [POS_W-1:0] pos_t;

	localparam tok_type_t TT_EOF      = 3'd0;
	localparam tok_type_t TT_UNKNOWN  = 3'd1;
	localparam tok_type_t TT_OPERATOR = 3'd2;
	localparam tok_type_t TT_DELIM    = 3'd3;
	localparam tok_type_t TT_KEYWORD  = 3'd4;
	localparam tok_type_t TT_IDENT    = 3'd5;
	localparam tok_type_t TT_INT      = 3'd6;
	localparam tok_type_t TT_DOUBLE   = 3'd7;

	localparam char_t CH_NL   = 8'h0A;
	localparam char_t CH_DOT  = 8'h2E;
	localparam char_t CH_ZERO = 8'h30;

	// keyword_alive bit order: int, double, return
	localparam tok_len_t KW_INT_LEN = 16'd3;
	localparam tok_len_t KW_DR_LEN  = 16'd6;

	typedef struct packed {
		tok_type_t ttype;
		tok_len_t  len;
		pos_t      start;
		pos_t      line;
		logic      last;
	} tok_t;

	function automatic logic [2:0] kw_mask(input tok_len_t idx, input char_t c);
		logic [2:0] m;
		m = '0;
		unique case (idx)
			16'd0: begin
				m[0] = (c == "i");
				m[1] = (c == "d");
				m[2] = (c == "r");
			end
			16'd1: begin
				m[0] = (c == "n");
				m[1] = (c == "o");
				m[2] = (c == "e");
			end
			16'd2: begin
				m[0] = (c == "t");
				m[1] = (c == "u");
				m[2] = (c == "t");
			end
			16'd3: begin
				m[1] = (c == "b");
				m[2] = (c == "u");
			end
			16'd4: begin
				m[1] = (c == "l");
				m[2] = (c == "r");
			end
			16'd5: begin
				m[1] = (c == "e");
				m[2] = (c == "n");
			end
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// File: hdl/tcl_ifs.sv
// tcl_byte_if and tcl_token_if: valid/ready channels of the lexer core.
// Depends on tcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tcl_byte_if;
	logic          valid;
	logic          ready;
	tcl_pkg::char_t ch;
	logic          end_of_input;

	modport source (output valid, output ch, output end_of_input, input ready);
	modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface tcl_token_if;
	logic                 valid;
	logic                 ready;
	tcl_pkg::tok_type_t   token_type;
	tcl_pkg::tok_len_t    token_length;
	tcl_pkg::pos_t        token_start;
	tcl_pkg::pos_t        token_line;
	logic                 last;

	modport source (output valid, output token_type, output token_length,
		output token_start, output token_line, output last, input ready);
	modport sink   (input valid, input token_type, input token_length,
		input token_start, input token_line, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/tiny_c_lexer_core.sv
// tiny_c_lexer_core: byte-serial DFA tokenizer for a tiny C subset.
// Depends on tcl_pkg and the channel interfaces in tcl_ifs.sv.
//
//   channel    dir   request              fields
//   byte_ch    in    one source byte      ch, end_of_input
//   token_ch   out   one token            token_type, token_length,
//                                         token_start, token_line, last
//
// One byte per cycle unless the input stalls: a request is registered, then scanned
// from the input register and its 0..2 tokens are written to a 4-entry result queue.
// An item that yields two tokens leaves as two output transfers; the queue absorbs them.
// Input stalls only when the queue holds more than two tokens.
// Reset (arst_n low) returns the scanner to start state, line one, offset zero.
`timescale 1ns / 1ps
`default_nettype none

module tiny_c_lexer_core (
	input  wire              clk,
	input  wire              arst_n,
	tcl_byte_if.sink         byte_ch,
	tcl_token_if.source      token_ch
);
	import tcl_pkg::*;

	localparam logic [1:0] ST_START = 2'd0;
	localparam logic [1:0] ST_IDENT = 2'd1;
	localparam logic [1:0] ST_INT   = 2'd2;
	localparam logic [1:0] ST_DBL   = 2'd3;

	// input register
	logic  vld_s1;
	char_t ch_s1;
	logic  eoi_s1;

	// scanner state
	logic [1:0] st_q;
	tok_len_t   len_q;
	pos_t       beg_q;
	pos_t       pos_q;
	pos_t       line_q;
	logic       plw_q;
	logic       lz_q;
	logic [2:0] alive_q;

	// result queue
	tok_t       q_mem [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	logic adv, pop;

	assign pop   = token_ch.valid && token_ch.ready;
	assign adv   = vld_s1 && (cnt_q <= 3'd2);
	assign byte_ch.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			vld_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			ch_s1  <= byte_ch.ch;
			eoi_s1 <= byte_ch.end_of_input;
		end
	end

	// character classes
	logic is_dig, is_let, is_spc, is_dlm, is_op;
	assign is_dig = (ch_s1 >= "0") && (ch_s1 <= "9");
	assign is_let = ((ch_s1 >= "A") && (ch_s1 <= "Z")) || ((ch_s1 >= "a") && (ch_s1 <= "z"));
	assign is_spc = (ch_s1 == " ") || ((ch_s1 >= 8'd9) && (ch_s1 <= 8'd13));
	assign is_dlm = (ch_s1 == ";") || (ch_s1 == ",") || (ch_s1 == "(") || (ch_s1 == ")")
		|| (ch_s1 == "{") || (ch_s1 == "}");
	assign is_op  = (ch_s1 == "+") || (ch_s1 == "-") || (ch_s1 == "*") || (ch_s1 == "/")
		|| (ch_s1 == "=");

	tok_type_t flush_type;
	always_comb begin
		unique case (st_q)
			ST_IDENT: flush_type = ((alive_q[0] && (len_q == KW_INT_LEN))
				|| (alive_q[1] && (len_q == KW_DR_LEN))
				|| (alive_q[2] && (len_q == KW_DR_LEN))) ? TT_KEYWORD : TT_IDENT;
			ST_INT:   flush_type = TT_INT;
			ST_DBL:   flush_type = TT_DOUBLE;
			default:  flush_type = TT_UNKNOWN;
		endcase
	end

	// scan step
	logic       a_v, b_v, rescan, do_app, do_beg;
	tok_t       a_tok, b_tok;
	logic [1:0] st_n;
	tok_len_t   len_n, app_len;
	pos_t       beg_n, pos_n, line_n;
	logic       plw_n, lz_n;
	logic [2:0] alive_n, app_alive;

	always_comb begin
		app_len   = (len_q != tok_len_t'(MAX_TOKEN_LEN)) ? len_q + 1'b1 : len_q;
		app_alive = alive_q & kw_mask(len_q, ch_s1);
		a_v    = 1'b0;
		b_v    = 1'b0;
		rescan = 1'b0;
		do_app = 1'b0;
		do_beg = 1'b0;
		a_tok  = '{ttype: flush_type, len: len_q, start: beg_q, line: line_q, last: 1'b0};
		b_tok  = '{ttype: TT_UNKNOWN, len: tok_len_t'(1), start: pos_q, line: line_q,
			last: 1'b1};
		st_n    = st_q;
		len_n   = len_q;
		beg_n   = beg_q;
		plw_n   = plw_q;
		lz_n    = lz_q;
		alive_n = alive_q;
		pos_n   = pos_q + 1'b1;
		line_n  = (ch_s1 == CH_NL) ? line_q + 1'b1 : line_q;

		if (eoi_s1) begin
			a_v         = (st_q != ST_START);
			b_v         = 1'b1;
			b_tok.ttype = TT_EOF;
			b_tok.len   = '0;
			st_n    = ST_START;
			len_n   = '0;
			beg_n   = '0;
			pos_n   = '0;
			line_n  = pos_t'(1);
			plw_n   = 1'b0;
			lz_n    = 1'b0;
			alive_n = 3'b111;
		end else begin
			unique case (st_q)
				ST_IDENT: begin
					if (is_dig || (is_let && plw_q)) begin
						do_app = 1'b1;
					end else if (is_let) begin
						do_app      = 1'b1;
						a_v         = 1'b1;
						a_tok.ttype = TT_UNKNOWN;
						a_tok.len   = app_len;
						st_n        = ST_START;
					end else begin
						a_v    = 1'b1;
						st_n   = ST_START;
						rescan = 1'b1;
					end
				end
				ST_INT: begin
					if (is_dig) begin
						do_app = 1'b1;
						if (lz_q) begin
							a_v         = 1'b1;
							a_tok.ttype = TT_UNKNOWN;
							a_tok.len   = app_len;
							st_n        = ST_START;
						end
					end else if (ch_s1 == CH_DOT) begin
						do_app = 1'b1;
						st_n   = ST_DBL;
					end else begin
						a_v    = 1'b1;
						st_n   = ST_START;
						rescan = 1'b1;
					end
				end
				ST_DBL: begin
					if (is_dig) begin
						do_app = 1'b1;
					end else begin
						a_v    = 1'b1;
						st_n   = ST_START;
						rescan = 1'b1;
					end
				end
				default: rescan = 1'b1;
			endcase

			if (rescan && !is_spc) begin
				if (is_dig) begin
					do_beg = 1'b1;
					st_n   = ST_INT;
				end else if (is_let) begin
					do_beg = 1'b1;
					st_n   = ST_IDENT;
				end else begin
					b_v = 1'b1;
					priority if (is_dlm) begin
						b_tok.ttype = TT_DELIM;
					end else if (is_op) begin
						b_tok.ttype = TT_OPERATOR;
					end else begin
						b_tok.ttype = TT_UNKNOWN;
					end
				end
			end

			if (do_app) begin
				len_n   = app_len;
				alive_n = app_alive;
				plw_n   = is_let;
				lz_n    = 1'b0;
			end
			if (do_beg) begin
				len_n   = tok_len_t'(1);
				beg_n   = pos_q;
				alive_n = kw_mask('0, ch_s1);
				plw_n   = is_let;
				lz_n    = (ch_s1 == CH_ZERO);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_START;
			len_q   <= '0;
			beg_q   <= '0;
			pos_q   <= '0;
			line_q  <= pos_t'(1);
			plw_q   <= 1'b0;
			lz_q    <= 1'b0;
			alive_q <= 3'b111;
		end else if (adv) begin
			st_q    <= st_n;
			len_q   <= len_n;
			beg_q   <= beg_n;
			pos_q   <= pos_n;
			line_q  <= line_n;
			plw_q   <= plw_n;
			lz_q    <= lz_n;
			alive_q <= alive_n;
		end
	end

	// result queue write
	tok_t       e0, e1;
	logic [1:0] push_n;

	always_comb begin
		e0      = a_v ? a_tok : b_tok;
		e0.last = !(a_v && b_v);
		e1      = b_tok;
		push_n  = adv ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q_mem[wr_q] <= e0;
		end
		if (push_n == 2'd2) begin
			q_mem[wr_q + 2'd1] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_n;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	assign token_ch.valid        = (cnt_q != 3'd0);
	assign token_ch.token_type   = q_mem[rd_q].ttype;
	assign token_ch.token_length = q_mem[rd_q].len;
	assign token_ch.token_start  = q_mem[rd_q].start;
	assign token_ch.token_line   = q_mem[rd_q].line;
	assign token_ch.last         = q_mem[rd_q].last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue count out of range");

	a_eoi_token: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eoi_s1 |-> push_n != 2'd0 && (push_n == 2'd2) == (st_q != ST_START))
		else $error("end of input did not queue its tokens");

	a_eoi_reset: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eoi_s1 |=> st_q == ST_START && pos_q == '0 && line_q == pos_t'(1))
		else $error("scanner not reset after end of input");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 |-> !e0.last && e1.last)
		else $error("last flag misplaced on token pair");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !eoi_s1 |=> pos_q == $past(pos_q) + 1'b1)
		else $error("byte offset did not advance");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// testbench: drives bytes into tiny_c_lexer_core and checks every token against
// an in-bench scanner model held by a small scoreboard class.
// Depends on tcl_pkg, tcl_ifs.sv and tiny_c_lexer_core.
`timescale 1ns / 1ps

module testbench;
	import tcl_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_BYTES   = 550;

	typedef enum logic [1:0] {SCAN_START, SCAN_IDENT, SCAN_INT, SCAN_DBL} scan_t;

	class token_scoreboard;
		tok_t        pending_tokens[$];
		int unsigned fail_count;
		scan_t       state;
		tok_len_t    tok_len;
		pos_t        tok_begin;
		pos_t        byte_pos;
		pos_t        line_no;
		logic        after_letter;
		logic        lone_zero;
		logic [2:0]  kw_alive;
		string       kw_word[3];

		function new();
			kw_word = '{"int", "double", "return"};
			fail_count = 0;
			clear();
		endfunction

		function void clear();
			state = SCAN_START;
			tok_len = '0;
			tok_begin = '0;
			byte_pos = '0;
			line_no = 1;
			after_letter = 1'b0;
			lone_zero = 1'b0;
			kw_alive = 3'b111;
		endfunction

		function bit is_digit(char_t c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_letter(char_t c);
			return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		endfunction

		function bit is_space(char_t c);
			return c == " " || (c >= 8'd9 && c <= 8'd13);
		endfunction

		function logic [2:0] kw_hits(tok_len_t idx, char_t c);
			logic [2:0] m;
			m = '0;
			for (int k = 0; k < 3; k++)
				if (idx < kw_word[k].len() && kw_word[k][idx] == c)
					m[k] = 1'b1;
			return m;
		endfunction

		function void push(tok_type_t t, tok_len_t n, pos_t s, pos_t l);
			tok_t e;
			e.ttype = t;
			e.len = n;
			e.start = s;
			e.line = l;
			e.last = 1'b0;
			pending_tokens.push_back(e);
		endfunction

		function void open_token(scan_t st, char_t c);
			state = st;
			tok_len = 1;
			tok_begin = byte_pos;
			kw_alive = kw_hits(0, c);
			after_letter = is_letter(c);
			lone_zero = (c == CH_ZERO);
		endfunction

		function void extend(char_t c);
			kw_alive &= kw_hits(tok_len, c);
			if (tok_len < MAX_TOKEN_LEN)
				tok_len++;
			after_letter = is_letter(c);
			lone_zero = 1'b0;
		endfunction

		function void close_token(pos_t l);
			tok_type_t t;
			t = TT_UNKNOWN;
			case (state)
				SCAN_IDENT: begin
					t = TT_IDENT;
					for (int k = 0; k < 3; k++)
						if (kw_alive[k] && tok_len == kw_word[k].len())
							t = TT_KEYWORD;
				end
				SCAN_INT: t = TT_INT;
				SCAN_DBL: t = TT_DOUBLE;
				default: t = TT_UNKNOWN;
			endcase
			push(t, tok_len, tok_begin, l);
			state = SCAN_START;
		endfunction

		function void scan_fresh(char_t c, pos_t l);
			if (is_space(c))
				return;
			if (is_digit(c))
				open_token(SCAN_INT, c);
			else if (is_letter(c))
				open_token(SCAN_IDENT, c);
			else if (c == ";" || c == "," || c == "(" || c == ")" || c == "{" || c == "}")
				push(TT_DELIM, 1, byte_pos, l);
			else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "=")
				push(TT_OPERATOR, 1, byte_pos, l);
			else
				push(TT_UNKNOWN, 1, byte_pos, l);
		endfunction

		function void note_byte(char_t c, logic eoi);
			int unsigned before_n;
			pos_t        l;
			bit          rescan;
			bit          err;
			before_n = pending_tokens.size();
			l = line_no;
			rescan = 1'b0;
			if (eoi) begin
				if (state != SCAN_START)
					close_token(l);
				push(TT_EOF, 0, byte_pos, l);
				pending_tokens[pending_tokens.size() - 1].last = 1'b1;
				clear();
				return;
			end
			case (state)
				SCAN_IDENT: begin
					if (is_digit(c) || (is_letter(c) && after_letter)) begin
						extend(c);
					end else if (is_letter(c)) begin
						extend(c);
						push(TT_UNKNOWN, tok_len, tok_begin, l);
						state = SCAN_START;
					end else begin
						close_token(l);
						rescan = 1'b1;
					end
				end
				SCAN_INT: begin
					if (is_digit(c)) begin
						err = lone_zero;
						extend(c);
						if (err) begin
							push(TT_UNKNOWN, tok_len, tok_begin, l);
							state = SCAN_START;
						end
					end else if (c == CH_DOT) begin
						extend(c);
						state = SCAN_DBL;
					end else begin
						close_token(l);
						rescan = 1'b1;
					end
				end
				SCAN_DBL: begin
					if (is_digit(c)) begin
						extend(c);
					end else begin
						close_token(l);
						rescan = 1'b1;
					end
				end
				default: rescan = 1'b1;
			endcase
			if (rescan)
				scan_fresh(c, l);
			if (c == CH_NL)
				line_no++;
			byte_pos++;
			if (pending_tokens.size() > before_n)
				pending_tokens[pending_tokens.size() - 1].last = 1'b1;
		endfunction

		function void check_token(tok_t got);
			tok_t want;
			if (pending_tokens.size() == 0) begin
				$error("unexpected token: type %0d start %0d", got.ttype, got.start);
				fail_count++;
				return;
			end
			want = pending_tokens.pop_front();
			if (got.ttype != want.ttype) begin
				$error("token_type: expected %0d, got %0d", want.ttype, got.ttype);
				fail_count++;
			end
			if (got.len != want.len) begin
				$error("token_length: expected %0d, got %0d", want.len, got.len);
				fail_count++;
			end
			if (got.start != want.start) begin
				$error("token_start: expected %0d, got %0d", want.start, got.start);
				fail_count++;
			end
			if (got.line != want.line) begin
				$error("token_line: expected %0d, got %0d", want.line, got.line);
				fail_count++;
			end
			if (got.last != want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				fail_count++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_tokens.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;

	int unsigned     random_bytes;
	int unsigned     idle_cycles;
	char_t           lexeme[$];
	token_scoreboard sb = new();

	tcl_byte_if  byte_ch();
	tcl_token_if token_ch();

	tiny_c_lexer_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.token_ch (token_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.ch = '0;
		byte_ch.end_of_input = 1'b0;
		token_ch.ready = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	function automatic char_t rand_letter();
		int unsigned r;
		r = $urandom_range(0, 51);
		return (r < 26) ? char_t'("a" + r) : char_t'("A" + r - 26);
	endfunction

	function automatic char_t rand_digit(int unsigned lo);
		return char_t'("0" + $urandom_range(lo, 9));
	endfunction

	task automatic send_byte(input char_t c, input logic eoi);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.ch <= c;
		byte_ch.end_of_input <= eoi;
		do @(posedge clk); while (!byte_ch.ready);
		sb.note_byte(c, eoi);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	task automatic add_word(input string s);
		for (int i = 0; i < s.len(); i++)
			lexeme.push_back(s[i]);
	endtask

	// mostly well-formed tokens, some error shapes, some raw noise
	task automatic build_lexeme();
		string kw[3];
		string ops;
		string delims;
		string spaces;
		kw = '{"int", "double", "return"};
		ops = "+-*/=";
		delims = ";,(){}";
		spaces = " \t\n\v\f\r";
		lexeme.delete();
		case ($urandom_range(0, 19))
			0, 1, 2: add_word(kw[$urandom_range(0, 2)]);
			3, 4, 5: begin
				repeat ($urandom_range(1, 6)) lexeme.push_back(rand_letter());
				repeat ($urandom_range(0, 3)) lexeme.push_back(rand_digit(0));
			end
			6: begin
				repeat ($urandom_range(1, 3)) lexeme.push_back(rand_letter());
				lexeme.push_back(rand_digit(0));
				lexeme.push_back(rand_letter());
			end
			7, 8: begin
				if ($urandom_range(0, 3) == 0) begin
					lexeme.push_back(CH_ZERO);
				end else begin
					lexeme.push_back(rand_digit(1));
					repeat ($urandom_range(0, 4)) lexeme.push_back(rand_digit(0));
				end
			end
			9: begin
				lexeme.push_back(CH_ZERO);
				lexeme.push_back(rand_digit(0));
			end
			10, 11: begin
				repeat ($urandom_range(1, 3)) lexeme.push_back(rand_digit(0));
				lexeme.push_back(CH_DOT);
				repeat ($urandom_range(0, 3)) lexeme.push_back(rand_digit(0));
				if ($urandom_range(0, 3) == 0)
					lexeme.push_back(CH_DOT);
			end
			12: lexeme.push_back(CH_DOT);
			13: lexeme.push_back(ops[$urandom_range(0, ops.len() - 1)]);
			14: lexeme.push_back(delims[$urandom_range(0, delims.len() - 1)]);
			15, 16: lexeme.push_back(spaces[$urandom_range(0, spaces.len() - 1)]);
			17: lexeme.push_back(char_t'($urandom_range(0, 255)));
			18: lexeme.push_back(char_t'($urandom_range(128, 255)));
			default: lexeme.push_back(" ");
		endcase
		if ($urandom_range(0, 1) == 0)
			lexeme.push_back(" ");
	endtask

	initial begin : token_sink
		int unsigned stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall != 0) begin
				token_ch.ready <= 1'b0;
				stall--;
			end else begin
				token_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : monitor
		tok_t seen;
		if (token_ch.valid === 1'b1 && token_ch.ready === 1'b1) begin
			seen.ttype = token_ch.token_type;
			seen.len = token_ch.token_length;
			seen.start = token_ch.token_start;
			seen.line = token_ch.token_line;
			seen.last = token_ch.last;
			sb.check_token(seen);
		end
		if (!arst_n || (byte_ch.valid && byte_ch.ready)
				|| (token_ch.valid && token_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tiny_c_lexer_core verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		quiet = 1'b0;
		idle_cycles = 0;
		random_bytes = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// keyword, bad identifier, bad leading zero, double then dot, extremes
		send_text("int a1b=01;0.5.\n");
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_text("{double");
		send_byte(8'hA5, 1'b1);

		while (random_bytes < RANDOM_BYTES) begin
			build_lexeme();
			if (lexeme.size() == 1 && lexeme[0] == " " && $urandom_range(0, 9) == 0) begin
				send_byte(char_t'($urandom_range(0, 255)), 1'b1);
				random_bytes++;
			end
			foreach (lexeme[i]) begin
				send_byte(lexeme[i], 1'b0);
				random_bytes++;
			end
			if ($urandom_range(0, 29) == 0)
				quiet = !quiet;
		end
		send_byte(8'h00, 1'b1);
		byte_ch.valid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.fail_count == 0)
			$display("tiny_c_lexer_core verification clean");
		else
			$display("tiny_c_lexer_core verification failed");
		$finish;
	end

endmodule
